[rtl/led_serial_frame_encoder_core_macros.svh]
// assertion macros for the serial led frame encoder
`ifndef LED_SERIAL_FRAME_ENCODER_CORE_MACROS_SVH
`define LED_SERIAL_FRAME_ENCODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define LSFE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsfe assertion failed");
`define LSFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsfe assertion failed");
`else
`define LSFE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LSFE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/lsfe_pkg.sv]
// shared types, constants and helpers of the serial led frame encoder
`timescale 1ns / 1ps
package lsfe_pkg;

  localparam int CNT_W = 17;

  localparam logic [CNT_W-1:0] MAX_PIXELS   = 17'd65536;
  localparam logic [7:0]       HDR_XOR      = 8'h55;
  localparam logic [7:0]       EXT_FORBID   = 8'h41;
  localparam logic [7:0]       EXT_REPL     = 8'haa;
  localparam logic [7:0]       CHR_UP_A     = 8'h41;
  localparam logic [7:0]       CHR_LO_W     = 8'h77;
  localparam logic [7:0]       CHR_UP_B     = 8'h42;
  localparam logic [7:0]       CHR_LO_B     = 8'h62;
  localparam logic [7:0]       MOD_BASE     = 8'd255;

  // register indexes
  localparam logic [2:0] REG_LED_COUNT   = 3'd0;
  localparam logic [2:0] REG_WHITE_EN    = 3'd1;
  localparam logic [2:0] REG_WHITE_LIMIT = 3'd2;
  localparam logic [2:0] REG_WHITE_RED   = 3'd3;
  localparam logic [2:0] REG_WHITE_GREEN = 3'd4;
  localparam logic [2:0] REG_WHITE_BLUE  = 3'd5;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } out_t;

  // one classified pixel waiting for the byte sequencer
  typedef struct packed {
    in_t         pix;
    logic        first;
    logic        last;
    logic        wcal;
    logic [15:0] hdr_cnt;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic sums_zero;
  } bk_stat_t;

  // mod-255 add of two bytes, each operand at most 255
  function automatic logic [7:0] mod255_add(logic [7:0] a, logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MOD_BASE}) s = s - {1'b0, MOD_BASE};
    if (s >= {1'b0, MOD_BASE}) s = s - {1'b0, MOD_BASE};
    return s[7:0];
  endfunction

endpackage

[rtl/lsfe_front.sv]
// front end: accepts pixels, tracks frame position, classifies each pixel
`timescale 1ns / 1ps
module lsfe_front import lsfe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  in_t              in_data,
  output logic             in_stall,
  input  logic [CNT_W-1:0] led_count,
  input  logic             white_en,
  input  q_stat_t          q_stat,
  output logic             push,
  output q_entry_t         push_entry
);

  logic [CNT_W-1:0] pix_idx_r;
  logic [CNT_W-1:0] pix_idx_nxt;
  logic [CNT_W-1:0] eff_cnt;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W:0]   idx_inc;
  logic             last;

  // zero count behaves as one, anything above the max saturates
  always_comb begin
    if (led_count == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (led_count > MAX_PIXELS) begin
      eff_cnt = MAX_PIXELS;
    end else begin
      eff_cnt = led_count;
    end
  end

  assign cnt_m1  = eff_cnt - CNT_W'(1);
  assign idx_inc = {1'b0, pix_idx_r} + (CNT_W+1)'(1);
  assign last    = idx_inc >= {1'b0, eff_cnt};

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    push_entry.pix     = in_data;
    push_entry.first   = (pix_idx_r == '0);
    push_entry.last    = last;
    push_entry.wcal    = white_en;
    push_entry.hdr_cnt = cnt_m1[15:0];
  end

  assign pix_idx_nxt = last ? '0 : idx_inc[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_idx_r <= '0;
    end else if (push) begin
      pix_idx_r <= pix_idx_nxt;
    end
  end

endmodule

[rtl/lsfe_queue.sv]
// two-entry queue between the front end and the byte sequencer
`timescale 1ns / 1ps
module lsfe_queue import lsfe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output q_entry_t head,
  output q_stat_t  q_stat
);

  q_entry_t   mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[rtl/lsfe_back.sv]
// byte sequencer: header, pixel bytes, white trailer, checksums, output register
`timescale 1ns / 1ps
module lsfe_back import lsfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  q_entry_t   head,
  input  q_stat_t    q_stat,
  output logic       pop,
  input  logic [7:0] white_limit,
  input  logic [7:0] white_red,
  input  logic [7:0] white_green,
  input  logic [7:0] white_blue,
  output logic       out_valid,
  output out_t       out_data,
  input  logic       out_stall,
  output bk_stat_t   bk_stat
);

  typedef enum logic [1:0] {
    PH_HDR,
    PH_PIX,
    PH_WHT,
    PH_CHK
  } phase_t;

  phase_t     phase_r;
  phase_t     phase_nxt;
  logic [2:0] idx_r;
  logic [2:0] idx_nxt;
  logic       busy_r;
  logic       busy_nxt;
  logic [7:0] sum_one_r;
  logic [7:0] sum_two_r;
  logic [7:0] sum_pos_r;
  logic [7:0] pos_r;
  logic       out_valid_r;
  out_t       out_data_r;

  phase_t     cur_phase;
  logic [2:0] cur_idx;
  logic       room;
  logic       fire;
  logic       closing;
  logic [7:0] cur_byte;
  logic       is_payload;
  logic [7:0] hi;
  logic [7:0] lo;
  logic [7:0] one_nxt;

  assign hi = head.hdr_cnt[15:8];
  assign lo = head.hdr_cnt[7:0];

  // a fresh item starts with the header only on the first pixel of a frame
  assign cur_phase = busy_r ? phase_r : (head.first ? PH_HDR : PH_PIX);
  assign cur_idx   = busy_r ? idx_r : 3'd0;

  assign room    = !out_valid_r || !out_stall;
  assign fire    = !q_stat.empty && room;
  assign closing = (cur_phase == PH_CHK) && (cur_idx == 3'd2);

  always_comb begin
    cur_byte   = '0;
    is_payload = 1'b0;
    unique case (cur_phase)
      PH_HDR: begin
        unique case (cur_idx)
          3'd0:    cur_byte = CHR_UP_A;
          3'd1:    cur_byte = CHR_LO_W;
          3'd2:    cur_byte = head.wcal ? CHR_UP_B : CHR_LO_B;
          3'd3:    cur_byte = hi;
          3'd4:    cur_byte = lo;
          default: cur_byte = hi ^ lo ^ HDR_XOR;
        endcase
      end
      PH_PIX: begin
        is_payload = 1'b1;
        unique case (cur_idx[2:1])
          2'd0:    cur_byte = head.pix.red;
          2'd1:    cur_byte = head.pix.green;
          default: cur_byte = head.pix.blue;
        endcase
      end
      PH_WHT: begin
        is_payload = 1'b1;
        unique case (cur_idx[1:0])
          2'd0:    cur_byte = white_limit;
          2'd1:    cur_byte = white_red;
          2'd2:    cur_byte = white_green;
          default: cur_byte = white_blue;
        endcase
      end
      default: begin
        unique case (cur_idx[1:0])
          2'd0:    cur_byte = sum_one_r;
          2'd1:    cur_byte = sum_two_r;
          default: cur_byte = (sum_pos_r == EXT_FORBID) ? EXT_REPL : sum_pos_r;
        endcase
      end
    endcase
  end

  assign one_nxt = mod255_add(sum_one_r, cur_byte);

  always_comb begin
    pop = 1'b0;
    if (fire) begin
      if (cur_phase == PH_PIX && cur_idx == 3'd5 && !head.last) pop = 1'b1;
      if (closing) pop = 1'b1;
    end
  end

  // next phase, byte index and busy flag after the current byte
  always_comb begin
    phase_nxt = cur_phase;
    idx_nxt   = cur_idx + 3'd1;
    busy_nxt  = 1'b1;
    unique case (cur_phase)
      PH_HDR: begin
        if (cur_idx == 3'd5) begin
          phase_nxt = PH_PIX;
          idx_nxt   = '0;
        end
      end
      PH_PIX: begin
        if (cur_idx == 3'd5) begin
          idx_nxt = '0;
          if (!head.last) begin
            busy_nxt = 1'b0;
          end else if (head.wcal) begin
            phase_nxt = PH_WHT;
          end else begin
            phase_nxt = PH_CHK;
          end
        end
      end
      PH_WHT: begin
        if (cur_idx == 3'd3) begin
          phase_nxt = PH_CHK;
          idx_nxt   = '0;
        end
      end
      default: begin
        if (cur_idx == 3'd2) begin
          busy_nxt = 1'b0;
          idx_nxt  = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR;
      idx_r       <= '0;
      busy_r      <= 1'b0;
      sum_one_r   <= '0;
      sum_two_r   <= '0;
      sum_pos_r   <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      if (room) out_valid_r <= fire;
      if (fire) begin
        out_data_r.out_byte  <= cur_byte;
        out_data_r.frame_end <= closing;
        phase_r              <= phase_nxt;
        idx_r                <= idx_nxt;
        busy_r               <= busy_nxt;

        if (is_payload) begin
          sum_pos_r <= mod255_add(sum_pos_r, cur_byte ^ pos_r);
          pos_r     <= pos_r + 8'd1;
          sum_one_r <= one_nxt;
          sum_two_r <= mod255_add(sum_two_r, one_nxt);
        end else if (closing) begin
          // frame closed: sums and position start over
          sum_one_r <= '0;
          sum_two_r <= '0;
          sum_pos_r <= '0;
          pos_r     <= '0;
        end
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data          = out_data_r;
  assign bk_stat.sums_zero = (sum_one_r == '0) && (sum_two_r == '0) &&
                             (sum_pos_r == '0) && (pos_r == '0);

endmodule

[rtl/led_serial_frame_encoder_core.sv]
// top level of the serial led frame encoder: config registers and the three stages
`timescale 1ns / 1ps
`include "led_serial_frame_encoder_core_macros.svh"
// usage
//   input channel in_valid / in_data / in_stall carries one rgb pixel per transaction
//   result channel out_valid / out_data / out_stall carries one frame byte per
//   transaction, frame_end marks the last checksum byte of a frame
//   apb port (psel, penable, pwrite, paddr, pwdata, prdata, pready) holds the
//   six registers at byte addresses 0, 4 .. 20; write only while the block is idle
// timing
//   an idle sequencer sends a pixel's first byte via a queue entry and the output register
//   the sequencer moves one byte per cycle while out_stall is low and a pixel is queued;
//   a mid-frame pixel gives 6 bytes, the first of a frame 12 (header), the last 3 or 7 more
//   (trailer); a two-entry queue lets the front take new pixels while bytes drain
// reset
//   synchronous active-low rst_n empties the queue and output register, clears
//   the frame position and sums, and loads register defaults
// stall
//   out_stall freezes the output byte; the sequencer waits, the queue fills and
//   then in_stall rises; no byte is lost or repeated
module led_serial_frame_encoder_core import lsfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // pixel input
  input  logic        in_valid,
  input  in_t         in_data,
  output logic        in_stall,
  // byte output
  output logic        out_valid,
  output out_t        out_data,
  input  logic        out_stall,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CNT_W-1:0] led_count_r;
  logic             white_en_r;
  logic [7:0]       white_limit_r;
  logic [7:0]       white_red_r;
  logic [7:0]       white_green_r;
  logic [7:0]       white_blue_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  logic     push;
  logic     pop;
  q_entry_t push_entry;
  q_entry_t head;
  q_stat_t  q_stat;
  bk_stat_t bk_stat;

  // register file, always ready
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r   <= CNT_W'(1);
      white_en_r    <= 1'b0;
      white_limit_r <= 8'hff;
      white_red_r   <= 8'hff;
      white_green_r <= 8'hff;
      white_blue_r  <= 8'hff;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LED_COUNT:   led_count_r   <= pwdata[CNT_W-1:0];
        REG_WHITE_EN:    white_en_r    <= pwdata[0];
        REG_WHITE_LIMIT: white_limit_r <= pwdata[7:0];
        REG_WHITE_RED:   white_red_r   <= pwdata[7:0];
        REG_WHITE_GREEN: white_green_r <= pwdata[7:0];
        REG_WHITE_BLUE:  white_blue_r  <= pwdata[7:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LED_COUNT:   prdata = {{(32-CNT_W){1'b0}}, led_count_r};
      REG_WHITE_EN:    prdata = {31'd0, white_en_r};
      REG_WHITE_LIMIT: prdata = {24'd0, white_limit_r};
      REG_WHITE_RED:   prdata = {24'd0, white_red_r};
      REG_WHITE_GREEN: prdata = {24'd0, white_green_r};
      REG_WHITE_BLUE:  prdata = {24'd0, white_blue_r};
      default:         prdata = '0;
    endcase
  end

  // front: frame position and pixel classification
  lsfe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .led_count  (led_count_r),
    .white_en   (white_en_r),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue
  lsfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // back: byte sequencer, checksums and output register
  lsfe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .white_limit (white_limit_r),
    .white_red   (white_red_r),
    .white_green (white_green_r),
    .white_blue  (white_blue_r),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .out_stall   (out_stall),
    .bk_stat     (bk_stat)
  );

  // checks
  `LSFE_ASSERT_IMPLY(a_no_push_full, clk, rst_n, push, !q_stat.full)
  `LSFE_ASSERT_IMPLY(a_no_pop_empty, clk, rst_n, pop, !q_stat.empty)
  `LSFE_ASSERT_NEXT(a_sums_clear, clk, rst_n, out_valid && !out_stall && out_data.frame_end, bk_stat.sums_zero)

endmodule

[dv/led_serial_frame_encoder_core_tb.sv]
// self-checking testbench of the serial led frame encoder core
`timescale 1ns / 1ps
module led_serial_frame_encoder_core_tb;
  import lsfe_pkg::*;

  // register indexes past the map, writes there must be ignored
  localparam logic [2:0] REG_UNMAPPED_A = 3'd6;
  localparam logic [2:0] REG_UNMAPPED_B = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_t         in_data = '0;
  logic        in_stall;
  logic        out_valid;
  out_t        out_data;
  logic        out_stall = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // pixels waiting for the driver, bytes the encoder still owes
  in_t  pending_pixels[$];
  out_t frame_bytes_due[$];
  int   mismatches = 0;
  logic no_gaps = 1'b0;

  // register mirror
  logic [16:0] cfg_led_count = 17'd1;
  logic        cfg_white_en = 1'b0;
  logic [7:0]  cfg_white_limit = 8'hff;
  logic [7:0]  cfg_white_red = 8'hff;
  logic [7:0]  cfg_white_green = 8'hff;
  logic [7:0]  cfg_white_blue = 8'hff;

  // frame position and running sums
  logic [16:0] pix_taken = '0;
  logic [7:0]  fl_one = '0;
  logic [7:0]  fl_two = '0;
  logic [7:0]  pos_sum = '0;
  logic [7:0]  pos_ctr = '0;

  led_serial_frame_encoder_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
    return 8'((int'(a) + int'(b)) % 255);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic closes);
    out_t o;
    o.out_byte  = b;
    o.frame_end = closes;
    frame_bytes_due.push_back(o);
  endtask

  // payload byte: goes into all three sums
  task automatic push_payload(input logic [7:0] b);
    pos_sum = add_mod255(pos_sum, b ^ pos_ctr);
    pos_ctr = pos_ctr + 8'd1;
    fl_one  = add_mod255(fl_one, b);
    fl_two  = add_mod255(fl_two, fl_one);
    push_byte(b, 1'b0);
  endtask

  // expected serial bytes for one accepted pixel
  task automatic encode_pixel(input in_t px);
    int unsigned span;
    logic [15:0] span_m1;
    span = 32'(cfg_led_count);
    // zero count behaves as one, counts past the maximum saturate
    if (span == 0) span = 1;
    if (span > 32'(MAX_PIXELS)) span = 32'(MAX_PIXELS);
    if (pix_taken == '0) begin
      span_m1 = 16'(span - 1);
      push_byte(CHR_UP_A, 1'b0);
      push_byte(CHR_LO_W, 1'b0);
      push_byte(cfg_white_en ? CHR_UP_B : CHR_LO_B, 1'b0);
      push_byte(span_m1[15:8], 1'b0);
      push_byte(span_m1[7:0], 1'b0);
      push_byte(span_m1[15:8] ^ span_m1[7:0] ^ HDR_XOR, 1'b0);
    end
    repeat (2) push_payload(px.red);
    repeat (2) push_payload(px.green);
    repeat (2) push_payload(px.blue);
    pix_taken = pix_taken + 17'd1;
    // a count lowered mid-frame below the pixels taken closes the frame here
    if (32'(pix_taken) >= span) begin
      if (cfg_white_en) begin
        push_payload(cfg_white_limit);
        push_payload(cfg_white_red);
        push_payload(cfg_white_green);
        push_payload(cfg_white_blue);
      end
      push_byte(fl_one, 1'b0);
      push_byte(fl_two, 1'b0);
      push_byte((pos_sum == EXT_FORBID) ? EXT_REPL : pos_sum, 1'b1);
      pix_taken = '0;
      fl_one    = '0;
      fl_two    = '0;
      pos_sum   = '0;
      pos_ctr   = '0;
    end
  endtask

  // apb write: setup cycle, access cycle, register taken at the access edge
  task automatic write_register(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LED_COUNT:   cfg_led_count = val[16:0];
      REG_WHITE_EN:    cfg_white_en = val[0];
      REG_WHITE_LIMIT: cfg_white_limit = val[7:0];
      REG_WHITE_RED:   cfg_white_red = val[7:0];
      REG_WHITE_GREEN: cfg_white_green = val[7:0];
      REG_WHITE_BLUE:  cfg_white_blue = val[7:0];
      default: ;
    endcase
  endtask

  task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    in_t px;
    px.red   = r;
    px.green = g;
    px.blue  = b;
    pending_pixels.push_back(px);
  endtask

  // registers are only touched once every pixel is in and every byte is out
  task automatic drain_frame_bytes();
    while (pending_pixels.size() != 0 || in_valid || frame_bytes_due.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [7:0] random_channel();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // pixel driver: next transaction once the current one is taken, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_pixel(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (pending_pixels.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 13)) begin
          in_data  <= pending_pixels.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // byte monitor: each transaction against the oldest owed byte, random stalls
  always @(posedge clk) begin : byte_monitor
    out_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_bytes_due.size() == 0) begin
        mismatches++;
        $display("%0t unexpected byte: expected none, actual %02h frame_end %0b",
                 $time, out_data.out_byte, out_data.frame_end);
      end else begin
        due = frame_bytes_due.pop_front();
        if (out_data.out_byte !== due.out_byte) begin
          mismatches++;
          $display("%0t out_byte: expected %02h, actual %02h",
                   $time, due.out_byte, out_data.out_byte);
        end
        if (out_data.frame_end !== due.frame_end) begin
          mismatches++;
          $display("%0t frame_end: expected %0b, actual %0b",
                   $time, due.frame_end, out_data.frame_end);
        end
      end
    end
    out_stall <= !no_gaps && ($urandom_range(0, 99) < 13);
  end

  initial begin : stimulus
    int          phase;
    int          n_items;
    int          random_pixels;
    logic [31:0] v;
    random_pixels = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: one pixel frames, white off
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'hff, 8'hff, 8'hff);
    // positional sum lands on the forbidden value and is replaced
    queue_pixel(8'hff, 8'h00, 8'h1a);
    drain_frame_bytes();

    // zero count acts as a one pixel frame
    write_register(REG_LED_COUNT, 32'd0);
    queue_pixel(8'haa, 8'h55, 8'h0f);
    drain_frame_bytes();

    // white trailer with extreme calibration bytes
    write_register(REG_WHITE_EN, 32'd1);
    write_register(REG_WHITE_LIMIT, 32'h00);
    write_register(REG_WHITE_RED, 32'hff);
    write_register(REG_WHITE_GREEN, 32'h80);
    write_register(REG_WHITE_BLUE, 32'h01);
    write_register(REG_LED_COUNT, 32'd3);
    queue_pixel(8'h01, 8'h02, 8'h04);
    queue_pixel(8'h80, 8'h40, 8'h20);
    queue_pixel(8'h10, 8'h08, 8'hff);
    drain_frame_bytes();

    // count past the top saturates, header shows ff ff
    write_register(REG_LED_COUNT, 32'h1ffff);
    write_register(REG_UNMAPPED_A, 32'hffff_ffff);
    write_register(REG_UNMAPPED_B, 32'h0);
    queue_pixel(8'h7f, 8'h80, 8'hfe);
    queue_pixel(8'h3c, 8'hc3, 8'h5a);
    drain_frame_bytes();
    // count lowered to the number of pixels taken and white turned off mid-frame
    write_register(REG_WHITE_EN, 32'd0);
    write_register(REG_LED_COUNT, 32'd2);
    queue_pixel(8'he1, 8'h1e, 8'h99);
    drain_frame_bytes();

    // full count, then white turned on before the frame is closed early
    write_register(REG_LED_COUNT, 32'd65536);
    queue_pixel(8'h11, 8'h22, 8'h33);
    drain_frame_bytes();
    write_register(REG_WHITE_EN, 32'd1);
    write_register(REG_LED_COUNT, 32'd5);
    queue_pixel(8'h44, 8'h55, 8'h66);
    queue_pixel(8'h77, 8'h88, 8'h99);
    drain_frame_bytes();
    write_register(REG_LED_COUNT, 32'd1);
    queue_pixel(8'hcc, 8'hdd, 8'hee);
    drain_frame_bytes();

    // random phases, frames often span a register change
    phase = 0;
    while (random_pixels < 140) begin
      no_gaps <= (phase == 3);
      case ($urandom_range(0, 9))
        0:       v = 32'd0;
        1:       v = $urandom_range(9, 20);
        default: v = $urandom_range(1, 6);
      endcase
      write_register(REG_LED_COUNT, v);
      if ($urandom_range(0, 1)) write_register(REG_WHITE_EN, $urandom_range(0, 1));
      if ($urandom_range(0, 1)) write_register(REG_WHITE_LIMIT, {24'd0, random_channel()});
      if ($urandom_range(0, 1)) write_register(REG_WHITE_RED, {24'd0, random_channel()});
      if ($urandom_range(0, 1)) write_register(REG_WHITE_GREEN, {24'd0, random_channel()});
      if ($urandom_range(0, 1)) write_register(REG_WHITE_BLUE, {24'd0, random_channel()});
      if ($urandom_range(0, 7) == 0) write_register(REG_UNMAPPED_B, $urandom);
      n_items = (phase == 3) ? 30 : $urandom_range(4, 20);
      repeat (n_items) queue_pixel(random_channel(), random_channel(), random_channel());
      random_pixels += n_items;
      drain_frame_bytes();
      phase++;
    end

    // tail: anything still coming out is an unexpected byte
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
